@@ sv/pcmq_pkg.sv @@
package pcmq_pkg;

    localparam int MAX_CORES_DEFAULT  = 8;
    localparam int RING_DEPTH_DEFAULT = 16;
    localparam int PAYLOAD_WORDS      = 4;

    localparam int CORE_W    = 8;
    localparam int CHANNEL_W = 32;
    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 4;
    localparam int STATUS_W  = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_CORE_LIMIT = 1'b0;
    localparam logic [COUNT_W-1:0] CORE_LIMIT_RESET = 4'd1;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_RECV = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CORE = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0]    word3;
        logic [WORD_W-1:0]    word2;
        logic [WORD_W-1:0]    word1;
        logic [WORD_W-1:0]    word0;
        logic [CHANNEL_W-1:0] channel;
    } msg_t;

    localparam int MSG_W      = $bits(msg_t);
    localparam int IN_DATA_W  = ((CORE_W + MSG_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATUS_W + MSG_W + 7) / 8) * 8;

endpackage

@@ sv/per_core_mailbox_queues.sv @@
// Send items, rejected items and empty receives deliver their result in the cycle after the
// transfer; a successful receive reads the message memory into a read register, and the
// S_READ state then copies it to the output register. A new item is accepted every cycle
// when the output is free or taken, but none while a receive's memory read is outstanding.
// Reset clears all ring pointers at once and sets the core limit register to 1; message
// slots are not cleared and the block accepts items right after reset.
module per_core_mailbox_queues #(
    parameter int MAX_CORES  = pcmq_pkg::MAX_CORES_DEFAULT,
    parameter int RING_DEPTH = pcmq_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcmq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pcmq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pcmq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: core, channel, word0, word1, word2, word3.
    input  logic [pcmq_pkg::IN_DATA_W-1:0]      s_tdata,
    // Fields from bit 0: kind.
    input  logic                                s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: status, out_channel, out_word0, out_word1, out_word2,
    // out_word3, then zero padding.
    output logic [pcmq_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int CW        = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int PW        = $clog2(RING_DEPTH);
    localparam int AW        = CW + PW;
    localparam int SLOTS     = 2 ** AW;
    localparam int MSG_W     = pcmq_pkg::MSG_W;
    localparam int PAD_W     = pcmq_pkg::OUT_DATA_W - pcmq_pkg::STATUS_W - MSG_W;
    localparam logic [pcmq_pkg::CORE_W-1:0] MaxCoresLimit = pcmq_pkg::CORE_W'(MAX_CORES);
    localparam logic [PW-1:0] LastSlot = PW'(RING_DEPTH - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [pcmq_pkg::COUNT_W-1:0] core_limit_reg;
    logic                         state_reg;
    logic [PW-1:0]                wr_ptr_reg [2**CW];
    logic [PW-1:0]                rd_ptr_reg [2**CW];
    logic [MSG_W-1:0]             msg_mem [SLOTS];
    logic [MSG_W-1:0]             rdata_reg;
    logic                         out_valid_reg;
    logic [pcmq_pkg::STATUS_W-1:0] out_status_reg;
    logic [MSG_W-1:0]             out_msg_reg;

    logic                         cfg_write;
    logic                         in_xfer;
    logic [pcmq_pkg::CORE_W-1:0]  in_core;
    logic [CW-1:0]                cidx;
    logic [pcmq_pkg::CORE_W-1:0]  limit;
    logic                         bad_core;
    logic [PW-1:0]                wp;
    logic [PW-1:0]                rp;
    logic [PW-1:0]                wp_next;
    logic [PW-1:0]                rp_next;
    logic                         ring_full;
    logic                         ring_empty;
    logic                         do_send;
    logic                         do_recv;
    logic [pcmq_pkg::STATUS_W-1:0] item_status;
    logic                         state_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pcmq_pkg::REG_CORE_LIMIT)
                       ? {{(pcmq_pkg::APB_DATA_W - pcmq_pkg::COUNT_W){1'b0}}, core_limit_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_limit_reg <= pcmq_pkg::CORE_LIMIT_RESET;
        end
        else if (cfg_write && paddr[2] == pcmq_pkg::REG_CORE_LIMIT)
        begin
            core_limit_reg <= pwdata[pcmq_pkg::COUNT_W-1:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_core  = s_tdata[pcmq_pkg::CORE_W-1:0];
    assign cidx     = in_core[CW-1:0];

    always_comb
    begin
        if ({{(pcmq_pkg::CORE_W - pcmq_pkg::COUNT_W){1'b0}}, core_limit_reg} > MaxCoresLimit)
        begin
            limit = MaxCoresLimit;
        end
        else
        begin
            limit = {{(pcmq_pkg::CORE_W - pcmq_pkg::COUNT_W){1'b0}}, core_limit_reg};
        end
    end

    assign bad_core   = (in_core >= limit);
    assign wp         = wr_ptr_reg[cidx];
    assign rp         = rd_ptr_reg[cidx];
    assign wp_next    = (wp == LastSlot) ? '0 : wp + PW'(1);
    assign rp_next    = (rp == LastSlot) ? '0 : rp + PW'(1);
    assign ring_full  = (wp_next == rp);
    assign ring_empty = (wp == rp);

    always_comb
    begin
        do_send = 1'b0;
        do_recv = 1'b0;
        if (bad_core)
        begin
            item_status = pcmq_pkg::ST_BAD_CORE;
        end
        else if (s_tuser == pcmq_pkg::KIND_SEND)
        begin
            item_status = ring_full ? pcmq_pkg::ST_FULL : pcmq_pkg::ST_DONE;
            do_send     = in_xfer && !ring_full;
        end
        else
        begin
            item_status = ring_empty ? pcmq_pkg::ST_EMPTY : pcmq_pkg::ST_DONE;
            do_recv     = in_xfer && !ring_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2**CW; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
            end
        end
        else
        begin
            if (do_send)
            begin
                wr_ptr_reg[cidx] <= wp_next;
            end
            if (do_recv)
            begin
                rd_ptr_reg[cidx] <= rp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_send)
        begin
            msg_mem[AW'({cidx, wp})] <= s_tdata[pcmq_pkg::CORE_W +: MSG_W];
        end
        if (do_recv)
        begin
            rdata_reg <= msg_mem[AW'({cidx, rp})];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (do_recv)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_READ)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (in_xfer)
            begin
                out_valid_reg <= !do_recv;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            out_status_reg <= pcmq_pkg::ST_DONE;
            out_msg_reg    <= rdata_reg;
        end
        else if (in_xfer && !do_recv)
        begin
            out_status_reg <= item_status;
            out_msg_reg    <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_msg_reg, out_status_reg};

endmodule
